// ===== rtl/core/stlb_pkg.sv =====
// ----------------------------------------------------------------------------
// stlb_pkg
// Shared sizes, command codes and cell-to-cell types for the sorted key table.
// ----------------------------------------------------------------------------
`default_nettype none

package stlb_pkg;

  localparam int DEPTH = 16;
  localparam int KEY_W = 32;
  localparam int POS_W = $clog2(DEPTH + 1);

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // broadcast from the top to every cell
  typedef struct packed {
    logic             upd;
    logic [POS_W-1:0] count;
    logic [KEY_W-1:0] key;
  } cell_ctl_t;

  // handed from cell i to cell i+1
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             shift;
    logic             lt;
  } cell_nbr_t;

  // per-cell compare results
  typedef struct packed {
    logic le;
    logic lt;
    logic sel;
  } cell_flag_t;

endpackage

`default_nettype wire

// ===== rtl/core/stlb_ifs.sv =====
// ----------------------------------------------------------------------------
// stlb_ifs
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface stlb_in_if;
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic [stlb_pkg::KEY_W-1:0] key;

  modport source (output valid, cmd, key, input ready);
  modport sink   (input valid, cmd, key, output ready);
endinterface

interface stlb_out_if;
  logic                       valid;
  logic                       ready;
  logic [stlb_pkg::POS_W-1:0] position;
  logic                       found;
  logic [stlb_pkg::KEY_W-1:0] found_key;
  logic                       status;

  modport source (output valid, position, found, found_key, status, input ready);
  modport sink   (input valid, position, found, found_key, status, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/stlb_cell.sv =====
// ----------------------------------------------------------------------------
// stlb_cell
// One slot of the sorted table: holds a key, compares it against the beat's
// key and shifts in its lower neighbor's key (or the new key) on insert.
// ----------------------------------------------------------------------------
`default_nettype none

module stlb_cell (
  input  wire logic                       clk,
  input  wire logic [stlb_pkg::POS_W-1:0] idx,
  input  wire stlb_pkg::cell_ctl_t        ctl,
  input  wire stlb_pkg::cell_nbr_t        prev,
  output      stlb_pkg::cell_nbr_t        nxt,
  output      stlb_pkg::cell_flag_t       flag
);

  logic [stlb_pkg::KEY_W-1:0] key_r;
  logic [stlb_pkg::KEY_W-1:0] key_nxt;
  logic                       occ;
  logic                       le;
  logic                       lt;
  logic                       shift;

  assign occ   = idx < ctl.count;
  assign le    = occ && (key_r <= ctl.key);
  assign lt    = occ && (key_r < ctl.key);
  // empty slots act as +inf so the new key lands at the first free one
  assign shift = !le;

  assign key_nxt = prev.shift ? prev.key : ctl.key;

  always_ff @(posedge clk) begin
    if (ctl.upd && shift) begin
      key_r <= key_nxt;
    end
  end

  assign nxt.key   = key_r;
  assign nxt.shift = shift;
  assign nxt.lt    = lt;

  assign flag.le  = le;
  assign flag.lt  = lt;
  assign flag.sel = occ && !lt && prev.lt;

endmodule

`default_nettype wire

// ===== rtl/core/sorted_table_lower_bound_core.sv =====
// ----------------------------------------------------------------------------
// sorted_table_lower_bound_core
// Insertion-sorted key table with lower-bound query, built as a chain of
// compare-and-shift cells.
// ----------------------------------------------------------------------------
//  channel  dir  beat fields
//  in_ch    in   cmd, key
//  out_ch   out  position, found, found_key, status
//
//  Every cell compares its key in parallel, and the insert shift happens in
//  the same edge that accepts the beat.
//  Result is registered; in_ch.ready stays high while the result register is
//  empty or being drained, so back-to-back beats run at full rate.
//  rst_n (synchronous) empties the table; stored keys are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_lower_bound_core (
  input  wire logic clk,
  input  wire logic rst_n,
  stlb_in_if.sink   in_ch,
  stlb_out_if.source out_ch
);

  localparam int D = stlb_pkg::DEPTH;

  logic [stlb_pkg::POS_W-1:0] count_r;
  logic [stlb_pkg::POS_W-1:0] count_nxt;
  logic                       ovld_r;
  logic [stlb_pkg::POS_W-1:0] opos_r;
  logic                       ofound_r;
  logic [stlb_pkg::KEY_W-1:0] okey_r;
  logic                       ostat_r;

  logic                       accept;
  logic                       full;
  logic                       is_ins;
  stlb_pkg::cell_ctl_t        ctl;
  stlb_pkg::cell_nbr_t        link [D+1];
  stlb_pkg::cell_flag_t       flag [D];
  logic [D-1:0]               le_v;
  logic [D-1:0]               lt_v;
  logic [D-1:0]               sel_v;
  logic [stlb_pkg::KEY_W-1:0] sel_key;
  logic [stlb_pkg::POS_W-1:0] pos_le;
  logic [stlb_pkg::POS_W-1:0] pos_lt;
  logic [stlb_pkg::POS_W-1:0] res_pos;
  logic                       res_found;
  logic [stlb_pkg::KEY_W-1:0] res_key;
  logic                       res_stat;

  assign accept = in_ch.valid && in_ch.ready;
  assign full   = count_r == stlb_pkg::POS_W'(D);
  assign is_ins = in_ch.cmd == stlb_pkg::CMD_INSERT;

  assign ctl.upd   = accept && is_ins && !full;
  assign ctl.count = count_r;
  assign ctl.key   = in_ch.key;

  assign link[0].key   = '0;
  assign link[0].shift = 1'b0;
  assign link[0].lt    = 1'b1;

  for (genvar i = 0; i < D; i++) begin : g_cell
    stlb_cell u_cell (
      .clk  (clk),
      .idx  (stlb_pkg::POS_W'(i)),
      .ctl  (ctl),
      .prev (link[i]),
      .nxt  (link[i+1]),
      .flag (flag[i])
    );
    assign le_v[i]  = flag[i].le;
    assign lt_v[i]  = flag[i].lt;
    assign sel_v[i] = flag[i].sel;
  end

  always_comb begin
    sel_key = '0;
    for (int i = 0; i < D; i++) begin
      sel_key = sel_key | (sel_v[i] ? link[i+1].key : '0);
    end
  end

  assign pos_le = stlb_pkg::POS_W'($countones(le_v));
  assign pos_lt = stlb_pkg::POS_W'($countones(lt_v));

  always_comb begin
    res_pos   = pos_lt;
    res_found = 1'b0;
    res_key   = '0;
    res_stat  = stlb_pkg::STATUS_OK;
    if (is_ins) begin
      if (full) begin
        res_pos  = count_r;
        res_stat = stlb_pkg::STATUS_FULL;
      end else begin
        res_pos = pos_le;
      end
    end else begin
      res_found = pos_lt < count_r;
      res_key   = sel_key;
    end
  end

  assign count_nxt = ctl.upd ? count_r + stlb_pkg::POS_W'(1) : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovld_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        ovld_r <= 1'b1;
      end else if (out_ch.ready) begin
        ovld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      opos_r   <= res_pos;
      ofound_r <= res_found;
      okey_r   <= res_key;
      ostat_r  <= res_stat;
    end
  end

  assign in_ch.ready      = !ovld_r || out_ch.ready;
  assign out_ch.valid     = ovld_r;
  assign out_ch.position  = opos_r;
  assign out_ch.found     = ofound_r;
  assign out_ch.found_key = okey_r;
  assign out_ch.status    = ostat_r;

  a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(sel_v)) else $error("multiple lower-bound cells selected");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= stlb_pkg::POS_W'(D)) else $error("fill count beyond depth");

  a_found_sel: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_ins && pos_lt < count_r) |-> (sel_v != '0))
    else $error("query hit without selected cell");

  a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_ins && !full) |=> count_r == $past(count_r) + stlb_pkg::POS_W'(1))
    else $error("insert did not grow table");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_ins && full) |=> (out_ch.status == stlb_pkg::STATUS_FULL) && $stable(count_r))
    else $error("full insert not dropped");

endmodule

`default_nettype wire

// ===== sim/stlb_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stlb_table_checker
// Watches the command and result channels of the sorted key table. Keeps its
// own sorted copy of the table, works out each answer as a command beat is
// accepted, and compares every result beat with the oldest outstanding answer.
// ----------------------------------------------------------------------------
module stlb_table_checker (
  input  logic clk,
  input  logic rst_n,
  stlb_in_if   in_ch,
  stlb_out_if  out_ch,
  output int   mismatches,
  output int   answers_due,
  output int   answers_seen,
  output int   inserts_refused,
  output int   query_hits
);

  typedef struct packed {
    logic [stlb_pkg::POS_W-1:0] position;
    logic                       found;
    logic [stlb_pkg::KEY_W-1:0] found_key;
    logic                       status;
  } answer_t;

  logic [stlb_pkg::KEY_W-1:0] table_keys [stlb_pkg::DEPTH];
  int                         table_fill;
  answer_t                    answer_q [$];

  function automatic answer_t insert_or_search(input logic cmd,
                                               input logic [stlb_pkg::KEY_W-1:0] key);
    answer_t a;
    int      p;
    int      i;
    a = '0;
    p = 0;
    if (cmd == stlb_pkg::CMD_INSERT) begin
      if (table_fill >= stlb_pkg::DEPTH) begin
        a.status   = stlb_pkg::STATUS_FULL;
        a.position = stlb_pkg::POS_W'(table_fill);
      end else begin
        for (i = 0; i < table_fill; i++)
          if (table_keys[i] <= key) p++;
        for (i = table_fill; i > p; i--)
          table_keys[i] = table_keys[i-1];
        table_keys[p] = key;
        table_fill++;
        a.status   = stlb_pkg::STATUS_OK;
        a.position = stlb_pkg::POS_W'(p);
      end
    end else begin
      for (i = 0; i < table_fill; i++)
        if (table_keys[i] < key) p++;
      a.position = stlb_pkg::POS_W'(p);
      a.status   = stlb_pkg::STATUS_OK;
      if (p < table_fill) begin
        a.found     = 1'b1;
        a.found_key = table_keys[p];
      end
    end
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    answer_t got;
    if (!rst_n) begin
      table_fill      = 0;
      answer_q.delete();
      mismatches      = 0;
      answers_due     = 0;
      answers_seen    = 0;
      inserts_refused = 0;
      query_hits      = 0;
    end else begin
      // result beat first: it always belongs to an earlier command beat
      if (out_ch.valid && out_ch.ready) begin
        got.position  = out_ch.position;
        got.found     = out_ch.found;
        got.found_key = out_ch.found_key;
        got.status    = out_ch.status;
        if (answer_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result beat with nothing outstanding: pos=%0d found=%0b key=%h st=%0b",
                     $time, got.position, got.found, got.found_key, got.status);
          mismatches++;
        end else begin
          want = answer_q.pop_front();
          if (want.position !== got.position || want.found !== got.found ||
              want.found_key !== got.found_key || want.status !== got.status) begin
            if (mismatches < 10)
              $display({"%0t: exp pos=%0d found=%0b key=%h st=%0b",
                        " | got pos=%0d found=%0b key=%h st=%0b"},
                       $time, want.position, want.found, want.found_key, want.status,
                       got.position, got.found, got.found_key, got.status);
            mismatches++;
          end
          answers_seen++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        want = insert_or_search(in_ch.cmd, in_ch.key);
        if (in_ch.cmd == stlb_pkg::CMD_INSERT && want.status == stlb_pkg::STATUS_FULL)
          inserts_refused++;
        if (in_ch.cmd == stlb_pkg::CMD_QUERY && want.found) query_hits++;
        answer_q.push_back(want);
      end
      answers_due = answer_q.size();
    end
  end

endmodule

// ===== sim/sorted_table_lower_bound_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_lower_bound_core_test
// Drives insert and lower-bound beats into the sorted key table: a directed
// opening on an empty and partly filled table, then random beats that fill
// it to overflow and search around stored keys. Bursty sender, stalling
// receiver with one long hold; answers are checked by stlb_table_checker.
// ----------------------------------------------------------------------------
module sorted_table_lower_bound_core_test;

  localparam int RANDOM_BEATS = 1730;
  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 400;

  logic clk;
  logic rst_n;

  stlb_in_if  in_ch ();
  stlb_out_if out_ch ();

  int mismatches;
  int answers_due;
  int answers_seen;
  int inserts_refused;
  int query_hits;

  int burst_left;
  int inserts_sent;
  int queries_sent;
  int quiet_cycles;
  logic [stlb_pkg::KEY_W-1:0] key_pool [$];

  sorted_table_lower_bound_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  stlb_table_checker u_table_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .mismatches      (mismatches),
    .answers_due     (answers_due),
    .answers_seen    (answers_seen),
    .inserts_refused (inserts_refused),
    .query_hits      (query_hits)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_beat(input logic cmd, input logic [stlb_pkg::KEY_W-1:0] key);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.cmd   = cmd;
    in_ch.key   = key;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    if (cmd == stlb_pkg::CMD_INSERT) begin
      if (inserts_sent < stlb_pkg::DEPTH) key_pool.push_back(key);
      inserts_sent++;
    end else begin
      queries_sent++;
    end
  endtask

  // extremes, random words, a small set of repeating keys, and stored keys +-1
  function automatic logic [stlb_pkg::KEY_W-1:0] pick_key();
    logic [stlb_pkg::KEY_W-1:0] k;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel >= 5 && key_pool.size() > 0) begin
      k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      k = k + stlb_pkg::KEY_W'($urandom_range(0, 2)) - stlb_pkg::KEY_W'(1);
    end else begin
      case (sel)
        0:       k = '0;
        1:       k = '1;
        4:       k = stlb_pkg::KEY_W'($urandom_range(0, 15)) << 8;
        default: k = stlb_pkg::KEY_W'($urandom);
      endcase
    end
    return k;
  endfunction

  initial begin
    int   n;
    logic cmd;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.cmd    = stlb_pkg::CMD_INSERT;
    in_ch.key    = '0;
    burst_left   = 0;
    inserts_sent = 0;
    queries_sent = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_beat(stlb_pkg::CMD_QUERY,  32'h0000_0000);
    send_beat(stlb_pkg::CMD_QUERY,  32'hFFFF_FFFF);
    send_beat(stlb_pkg::CMD_INSERT, 32'h0000_0500);
    send_beat(stlb_pkg::CMD_INSERT, 32'h0000_0500);
    send_beat(stlb_pkg::CMD_INSERT, 32'h0000_0000);
    send_beat(stlb_pkg::CMD_QUERY,  32'hFFFF_FFFF);
    send_beat(stlb_pkg::CMD_QUERY,  32'h0000_0500);
    send_beat(stlb_pkg::CMD_QUERY,  32'h0000_04FF);
    send_beat(stlb_pkg::CMD_QUERY,  32'h0000_0501);
    send_beat(stlb_pkg::CMD_QUERY,  32'h0000_0000);
    send_beat(stlb_pkg::CMD_INSERT, 32'hFFFF_FFFF);
    send_beat(stlb_pkg::CMD_INSERT, 32'hAAAA_AAAA);
    send_beat(stlb_pkg::CMD_INSERT, 32'h5555_5555);
    send_beat(stlb_pkg::CMD_INSERT, 32'h0000_0500);
    send_beat(stlb_pkg::CMD_QUERY,  32'hFFFF_FFFF);
    send_beat(stlb_pkg::CMD_QUERY,  32'hAAAA_AAAA);
    send_beat(stlb_pkg::CMD_QUERY,  32'h5555_5556);

    // inserts are sparse so each fill level sees many searches; a few are
    // forced so the table always overflows
    for (n = 0; n < RANDOM_BEATS; n++) begin
      if (inserts_sent < stlb_pkg::DEPTH + 4 && n % 64 == 32)
        cmd = stlb_pkg::CMD_INSERT;
      else
        cmd = ($urandom_range(0, 19) == 0) ? stlb_pkg::CMD_INSERT : stlb_pkg::CMD_QUERY;
      send_beat(cmd, pick_key());
    end

    @(negedge clk);
    in_ch.valid = 1'b0;
    wait (answers_due == 0);
    repeat (4) @(posedge clk);

    $display("run: %0d inserts (%0d refused on a full table), %0d searches (%0d hits)",
             inserts_sent, inserts_refused, queries_sent, query_hits);
    $display("run: %0d result beats checked, %0d mismatches", answers_seen, mismatches);
    if (mismatches == 0 && answers_due == 0) begin
      $display("[sorted_table_lower_bound_core] OK");
    end else begin
      $display("[sorted_table_lower_bound_core] ERROR");
    end
    $finish;
  end

  // receiver: random stall patterns, one long hold early while beats keep coming
  initial begin
    int  seg;
    int  mode;
    int  span;
    int  c;
    bit  held;
    out_ch.ready = 1'b0;
    held = 1'b0;
    seg  = 0;
    wait (rst_n === 1'b1);
    forever begin
      seg++;
      if (!held && seg == 4) begin
        held = 1'b1;
        for (c = 0; c < HOLD_CYCLES; c++) begin
          @(negedge clk);
          out_ch.ready = 1'b0;
        end
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(4, 80);
        for (c = 0; c < span; c++) begin
          @(negedge clk);
          case (mode)
            0:       out_ch.ready = 1'b1;
            1:       out_ch.ready = $urandom_range(0, 1);
            2:       out_ch.ready = ($urandom_range(0, 4) != 0);
            default: out_ch.ready = ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
    $display("[sorted_table_lower_bound_core] ERROR");
    $finish;
  end

endmodule
